>>> sv/text_console_writer_core_defines.svh
// Assertion macros shared by the console writer RTL.
// Both macros disable the check while rst is high.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/tcw_pkg.sv
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_SCREEN_ROWS = 25;
  localparam int DEF_SCREEN_COLS = 80;

  // Queue depths between input, sequencer and result side
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  // Function codes on the func port
  localparam logic [2:0] FUNC_PUT_CHAR = 3'd0;
  localparam logic [2:0] FUNC_SET_POS  = 3'd1;
  localparam logic [2:0] FUNC_END_STR  = 3'd2;
  localparam logic [2:0] FUNC_READ     = 3'd3;
  localparam logic [2:0] FUNC_CLEAR    = 3'd4;

  // Control characters
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  // Configuration register indexes
  localparam logic REG_DEFAULT_ATTRIBUTE = 1'b0;
  localparam logic REG_TAB_WIDTH         = 1'b1;

  // Register reset values
  localparam logic [7:0] ATTR_RESET = 8'd15;
  localparam logic [3:0] TAB_RESET  = 4'd4;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_SET_POS,
    OP_END_STR,
    OP_READ,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    CK_PRINT,
    CK_TAB,
    CK_NEWLINE
  } char_kind_t;

  // Decoded command from the front end
  typedef struct packed {
    op_t        op;
    char_kind_t kind;
    logic [7:0] ch;
    logic [4:0] pos_row;
    logic [6:0] pos_col;
    logic       pos_ok;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       scrolled;
  } res_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_WIPE,
    ST_WIPE_END,
    ST_READ
  } state_t;

endpackage

>>> sv/tcw_fifo.sv
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/tcw_front.sv
module tcw_front #(
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    func,
  input  logic [7:0]    character,
  input  logic [4:0]    pos_row,
  input  logic [6:0]    pos_col,
  input  logic          init_busy,
  output logic          cmd_valid,
  output tcw_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  import tcw_pkg::*;

  cmd_t                   dec;
  logic                   q_full;
  logic                   q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  // Classify the incoming item
  always_comb begin
    dec.ch      = character;
    dec.pos_row = pos_row;
    dec.pos_col = pos_col;
    dec.pos_ok  = (32'(pos_row) < 32'(SCREEN_ROWS)) && (32'(pos_col) < 32'(SCREEN_COLS));
    case (func)
      FUNC_PUT_CHAR: dec.op = OP_PUT;
      FUNC_SET_POS:  dec.op = OP_SET_POS;
      FUNC_END_STR:  dec.op = OP_END_STR;
      FUNC_READ:     dec.op = OP_READ;
      FUNC_CLEAR:    dec.op = OP_CLEAR;
      default:       dec.op = OP_NONE;
    endcase
    case (character)
      CHAR_TAB:     dec.kind = CK_TAB;
      CHAR_NEWLINE: dec.kind = CK_NEWLINE;
      default:      dec.kind = CK_PRINT;
    endcase
  end

  // No transfers while the store is swept after reset
  assign full      = q_full || init_busy;
  assign cmd_valid = !q_empty;
  assign cmd       = cmd_t'(q_rdata);

  tcw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .wdata (dec),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

endmodule

>>> sv/tcw_back.sv
`include "text_console_writer_core_defines.svh"

module tcw_back #(
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  tcw_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  output logic          init_busy,
  output logic          res_empty,
  input  logic          res_pop,
  output tcw_pkg::res_t res
);

  import tcw_pkg::*;

  localparam int RW     = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int CW     = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
  localparam int NCELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CXW    = CW + 5;

  // Cell store, character and attribute halves
  logic [7:0] char_mem [NCELLS];
  logic [7:0] attr_mem [NCELLS];

  state_t        state, state_next;
  logic [RW-1:0] top_row, top_row_next;
  logic [RW-1:0] work_row, work_row_next;
  logic [CW-1:0] work_col, work_col_next;
  logic [RW-1:0] cursor_row, cursor_row_next;
  logic [CW-1:0] cursor_col, cursor_col_next;
  logic [AW-1:0] cnt, cnt_next;
  logic [7:0]    default_attribute;
  logic [3:0]    tab_width;

  logic [7:0]    rd_char;
  logic [7:0]    rd_attr;
  logic          char_we;
  logic          attr_we;
  logic [7:0]    char_wd;
  logic [7:0]    attr_wd;
  logic          flat_addr;
  logic [RW-1:0] lrow;
  logic [CW-1:0] lcol;
  logic [RW:0]   phys_sum;
  logic [RW-1:0] phys_row;
  logic [AW-1:0] addr;

  logic [CXW-1:0] col_ext;
  logic [RW:0]    row_ext;
  logic           put_ovf;
  logic [RW-1:0]  put_row;
  logic [CW-1:0]  put_col;

  logic           res_push;
  logic           res_full;
  res_t           res_data;
  logic [$bits(res_t)-1:0] res_rdata;
  logic           walk_last;
  logic           row_last;

  assign init_busy = (state == ST_INIT);
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid && !res_full;
  assign walk_last = (cnt == AW'(NCELLS - 1));
  assign row_last  = (cnt == AW'(SCREEN_COLS - 1));

  // Put-char position update with wrap, tab saturation and scroll detect
  always_comb begin
    case (cmd.kind)
      CK_TAB:     col_ext = CXW'(work_col) + CXW'(tab_width);
      CK_NEWLINE: col_ext = '0;
      default:    col_ext = CXW'(work_col) + CXW'(1);
    endcase
    row_ext = (cmd.kind == CK_NEWLINE) ? {1'b0, work_row} + 1'b1 : {1'b0, work_row};
    if (col_ext >= CXW'(SCREEN_COLS)) begin
      col_ext = col_ext - CXW'(SCREEN_COLS);
      row_ext = row_ext + 1'b1;
      if (col_ext >= CXW'(SCREEN_COLS)) begin
        col_ext = CXW'(SCREEN_COLS - 1);
      end
    end
    put_ovf = (row_ext >= (RW + 1)'(SCREEN_ROWS));
    put_row = put_ovf ? RW'(SCREEN_ROWS - 1) : RW'(row_ext);
    put_col = CW'(col_ext);
  end

  // Logical row to physical cell address (rows rotate on scroll)
  always_comb begin
    phys_sum = {1'b0, lrow} + {1'b0, top_row};
    if (phys_sum >= (RW + 1)'(SCREEN_ROWS)) begin
      phys_sum = phys_sum - (RW + 1)'(SCREEN_ROWS);
    end
    phys_row = RW'(phys_sum);
    addr = flat_addr ? cnt : AW'(phys_row) * AW'(SCREEN_COLS) + AW'(lcol);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (walk_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd.op)
            OP_PUT:   if (put_ovf) state_next = ST_SCROLL;
            OP_READ:  if (cmd.pos_ok) state_next = ST_READ;
            OP_CLEAR: state_next = ST_WIPE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCROLL: begin
        if (row_last) state_next = ST_SCROLL_END;
      end
      ST_WIPE: begin
        if (walk_last) state_next = ST_WIPE_END;
      end
      ST_SCROLL_END: state_next = ST_IDLE;
      ST_WIPE_END:   state_next = ST_IDLE;
      ST_READ:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Outputs: store access, register updates and result push
  always_comb begin
    top_row_next    = top_row;
    work_row_next   = work_row;
    work_col_next   = work_col;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    cnt_next        = '0;
    char_we         = 1'b0;
    attr_we         = 1'b0;
    char_wd         = '0;
    attr_wd         = '0;
    flat_addr       = 1'b0;
    lrow            = work_row;
    lcol            = work_col;
    res_push        = 1'b0;
    res_data.read_char = '0;
    res_data.read_attr = '0;
    res_data.scrolled  = 1'b0;
    case (state)
      ST_INIT, ST_WIPE: begin
        flat_addr = 1'b1;
        char_we   = 1'b1;
        attr_we   = 1'b1;
        cnt_next  = cnt + 1'b1;
      end
      ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd.op)
            OP_PUT: begin
              if (cmd.kind == CK_PRINT) begin
                char_we = 1'b1;
                attr_we = 1'b1;
                char_wd = cmd.ch;
                attr_wd = default_attribute;
              end
              work_row_next = put_row;
              work_col_next = put_col;
              res_push      = !put_ovf;
            end
            OP_SET_POS: begin
              work_row_next = cmd.pos_ok ? RW'(cmd.pos_row) : cursor_row;
              work_col_next = cmd.pos_ok ? CW'(cmd.pos_col) : cursor_col;
              res_push      = 1'b1;
            end
            OP_END_STR: begin
              cursor_row_next = work_row;
              cursor_col_next = work_col;
              attr_we         = 1'b1;
              attr_wd         = default_attribute;
              res_push        = 1'b1;
            end
            OP_READ: begin
              lrow     = RW'(cmd.pos_row);
              lcol     = CW'(cmd.pos_col);
              res_push = !cmd.pos_ok;
            end
            OP_CLEAR: begin
              top_row_next = '0;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // clear the old top row, which becomes the bottom row
        lrow     = '0;
        lcol     = CW'(cnt);
        char_we  = 1'b1;
        attr_we  = 1'b1;
        cnt_next = cnt + 1'b1;
        if (row_last) begin
          top_row_next = (top_row == RW'(SCREEN_ROWS - 1)) ? '0 : top_row + 1'b1;
        end
      end
      ST_SCROLL_END: begin
        lrow            = RW'(SCREEN_ROWS - 1);
        lcol            = '0;
        cursor_row_next = RW'(SCREEN_ROWS - 1);
        cursor_col_next = '0;
        attr_we         = 1'b1;
        attr_wd         = default_attribute;
        res_push        = 1'b1;
        res_data.scrolled = 1'b1;
      end
      ST_WIPE_END: begin
        lrow            = '0;
        lcol            = '0;
        work_row_next   = '0;
        work_col_next   = '0;
        cursor_row_next = '0;
        cursor_col_next = '0;
        attr_we         = 1'b1;
        attr_wd         = default_attribute;
        res_push        = 1'b1;
      end
      ST_READ: begin
        res_push           = 1'b1;
        res_data.read_char = rd_char;
        res_data.read_attr = rd_attr;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
    res_data.cursor_row = 5'(cursor_row_next);
    res_data.cursor_col = 7'(cursor_col_next);
  end

  // Cell store, one address per cycle, registered read
  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[addr] <= char_wd;
    end
    rd_char <= char_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[addr] <= attr_wd;
    end
    rd_attr <= attr_mem[addr];
  end

  // Sequencer and position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      top_row    <= '0;
      work_row   <= '0;
      work_col   <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      top_row    <= top_row_next;
      work_row   <= work_row_next;
      work_col   <= work_col_next;
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      cnt        <= cnt_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_attribute <= ATTR_RESET;
      tab_width         <= TAB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_ATTRIBUTE: default_attribute <= cfg_data;
        REG_TAB_WIDTH:         tab_width         <= cfg_data[3:0];
        default:               tab_width         <= tab_width;
      endcase
    end
  end

  // Result queue
  tcw_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .pop   (res_pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (res_empty)
  );

  assign res = res_t'(res_rdata);

  `TCW_ASSERT_IMP(a_res_no_overflow, clk, rst, res_push, !res_full, "result queue overflow")
  `TCW_ASSERT_IMP(a_cursor_in_range, clk, rst, 1'b1, (32'(cursor_row) < 32'(SCREEN_ROWS)) && (32'(cursor_col) < 32'(SCREEN_COLS)), "cursor out of range")
  `TCW_ASSERT_IMP(a_scroll_result, clk, rst, state == ST_SCROLL_END, res_push && res_data.scrolled && (work_row == RW'(SCREEN_ROWS - 1)), "scroll finished without result")
  `TCW_ASSERT_NXT(a_clear_starts, clk, rst, cmd_pop && (cmd.op == OP_CLEAR), (state == ST_WIPE) && (top_row == '0) && (cnt == '0), "clear did not start a sweep")

endmodule

>>> sv/text_console_writer_core.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// input    | push / full               | func, character, pos_row, pos_col
// result   | pop / empty               | read_char, read_attr, cursor_row,
//          |                           | cursor_col, scrolled
// config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// Commands leave the queue one per cycle while the sequencer is idle and the
// result queue has room; an in-range read passes ST_READ (registered store
// read), a put char that scrolls ST_SCROLL and ST_SCROLL_END, and a clear
// ST_WIPE and ST_WIPE_END, sweeping the single-port cell store. After reset
// the store is swept with full held high; config writes are taken throughout.
// Two-entry command and result queues let input and result sides stall apart.
module text_console_writer_core #(
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] func,
  input  logic [7:0] character,
  input  logic [4:0] pos_row,
  input  logic [6:0] pos_col,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_char,
  output logic [7:0] read_attr,
  output logic [4:0] cursor_row,
  output logic [6:0] cursor_col,
  output logic       scrolled,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  import tcw_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid;
  logic cmd_pop;
  logic init_busy;

  // Front end: accept and decode
  tcw_front #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .character (character),
    .pos_row   (pos_row),
    .pos_col   (pos_col),
    .init_busy (init_busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: execute against the cell store
  tcw_back #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .init_busy (init_busy),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign read_char  = res.read_char;
  assign read_attr  = res.read_attr;
  assign cursor_row = res.cursor_row;
  assign cursor_col = res.cursor_col;
  assign scrolled   = res.scrolled;

endmodule
